// File: hdl/icr_pkg.sv
// Shared types, constants and helper functions for the independent cascade run unit.
// Depends on nothing; every other file in this folder uses it.
`default_nettype none

package icr_pkg;

   // Graph sizing.
   localparam int MAX_NODES = 1024;
   localparam int MAX_ARCS  = 8192;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int ARC_W     = $clog2(MAX_ARCS);
   localparam int ARCS_W    = ARC_W + 1;
   localparam int COUNT_W   = NODE_W + 1;

   // Field and register widths.
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int THRESH_W    = 33;
   localparam int SEED_W      = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 33;

   // Register reset values.
   localparam logic [THRESH_W-1:0] THRESH_RESET = 33'd429496730;
   localparam logic [SEED_W-1:0]   SEED_RESET   = 32'd5489;

   // Mersenne twister constants.
   localparam int TW_N     = 624;
   localparam int TW_M     = 397;
   localparam int TW_IDX_W = 10;
   localparam logic [31:0] TW_SEED_MULT = 32'd1812433253;
   localparam logic [31:0] TW_MATRIX    = 32'h9908B0DF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD_EDGE = 2'd0,
      ACT_RUN      = 2'd1,
      ACT_CLEAR    = 2'd2,
      ACT_RESEED   = 2'd3
   } icr_action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } icr_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_SEED       = 2'd1,
      CSR_NODE_COUNT = 2'd2
   } icr_csr_type;

   // One per-node list descriptor.
   typedef struct packed {
      logic             nonempty;
      logic [ARC_W-1:0] first;
      logic [ARC_W-1:0] last;
   } icr_node_type;

   // Commands from the sequencer to the twister.
   typedef struct packed {
      logic              seed;
      logic              draw;
      logic [SEED_W-1:0] seed_value;
   } icr_tw_req_type;

   // Twister status back to the sequencer.
   typedef struct packed {
      logic        busy;
      logic        word_valid;
      logic [31:0] word;
   } icr_tw_rsp_type;

   // Output tempering of one twister word.
   function automatic logic [31:0] icr_temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & 32'h9D2C5680);
      y = y ^ ((y << 15) & 32'hEFC60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

// File: hdl/icr_req_if.sv
// Request channel of the cascade run unit: valid/ready plus one input item.
// Depends on icr_pkg for the field widths.
`default_nettype none

interface icr_req_if;
   logic                          valid;
   logic                          ready;
   logic [icr_pkg::ACTION_W-1:0]  action;
   logic [icr_pkg::NODE_W-1:0]    node_a;
   logic [icr_pkg::NODE_W-1:0]    node_b;

   modport source (output valid, output action, output node_a, output node_b, input ready);
   modport sink   (input valid, input action, input node_a, input node_b, output ready);
endinterface

`default_nettype wire

// File: hdl/icr_rsp_if.sv
// Response channel of the cascade run unit: valid/ready plus one result item.
// Depends on icr_pkg for the field widths.
`default_nettype none

interface icr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [icr_pkg::COUNT_W-1:0]   active_total;
   logic [icr_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output active_total, output status, input ready);
   modport sink   (input valid, input active_total, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/icr_twister.sv
// MT19937 generator: state memory, one 32x32 multiplier for seeding and a small sequencer.
// Depends on icr_pkg for constants, command and status types and the tempering function.
`default_nettype none

module icr_twister (
   input  wire                     clock,
   input  wire                     reset,
   input  icr_pkg::icr_tw_req_type tw_req,
   output icr_pkg::icr_tw_rsp_type tw_rsp
);
   import icr_pkg::*;

   typedef enum logic [3:0] {
      T_IDLE, T_SEED_MUL, T_SEED_ADD, T_RG_LOAD, T_RG_FIRST,
      T_RG_A, T_RG_B, T_RG_C, T_DR_A, T_DR_B
   } tw_state_type;

   localparam logic [TW_IDX_W-1:0] TW_LAST  = TW_IDX_W'(TW_N - 1);
   localparam logic [TW_IDX_W-1:0] TW_COUNT = TW_IDX_W'(TW_N);

   tw_state_type         state_ff, state_in;
   logic [TW_IDX_W-1:0]  idx_ff, idx_in;
   logic [TW_IDX_W-1:0]  pos_ff, pos_in;
   logic [31:0]          prev_ff, prev_in;
   logic [31:0]          prod_ff, prod_in;
   logic [31:0]          cur_ff, cur_in;
   logic [31:0]          nxt_ff, nxt_in;
   logic [31:0]          word_ff, word_in;
   logic                 word_valid_ff, word_valid_in;

   logic [31:0]          tw_mem [TW_N];
   logic [31:0]          rd_ff;
   logic [TW_IDX_W-1:0]  rd_addr;
   logic [TW_IDX_W-1:0]  wr_addr;
   logic [31:0]          wr_data;
   logic                 wr_en;

   // Next state, memory control and datapath of the sequencer.
   always_comb begin
      logic [31:0]         mix;
      logic [31:0]         seed_val;
      logic [31:0]         y;
      logic [31:0]         v;
      logic [TW_IDX_W:0]   sum_m;
      logic [TW_IDX_W-1:0] idx_p1;
      logic [TW_IDX_W-1:0] idx_pm;

      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      prev_in       = prev_ff;
      prod_in       = prod_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      word_in       = word_ff;
      word_valid_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;
      rd_addr       = idx_ff;

      mix      = prev_ff ^ (prev_ff >> 30);
      seed_val = prod_ff + 32'(idx_ff);
      y        = {cur_ff[31], nxt_ff[30:0]};
      v        = rd_ff ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
      idx_p1   = (idx_ff == TW_LAST) ? '0 : idx_ff + 1'b1;
      sum_m    = {1'b0, idx_ff} + (TW_IDX_W + 1)'(TW_M);
      if (sum_m >= (TW_IDX_W + 1)'(TW_N)) begin
         sum_m = sum_m - (TW_IDX_W + 1)'(TW_N);
      end
      idx_pm   = sum_m[TW_IDX_W-1:0];

      unique case (state_ff)
         T_IDLE: begin
            if (tw_req.seed) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = tw_req.seed_value;
               prev_in  = tw_req.seed_value;
               idx_in   = TW_IDX_W'(1);
               state_in = T_SEED_MUL;
            end else if (tw_req.draw) begin
               state_in = (pos_ff >= TW_COUNT) ? T_RG_LOAD : T_DR_A;
            end
         end
         // Seeding: one multiply, then the add and write.
         T_SEED_MUL: begin
            prod_in  = TW_SEED_MULT * mix;
            state_in = T_SEED_ADD;
         end
         T_SEED_ADD: begin
            wr_en   = 1'b1;
            wr_data = seed_val;
            prev_in = seed_val;
            if (idx_ff == TW_LAST) begin
               pos_in   = TW_COUNT;
               state_in = T_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = T_SEED_MUL;
            end
         end
         // Regeneration: each word goes through T_RG_A, T_RG_B and T_RG_C, in place.
         T_RG_LOAD: begin
            rd_addr  = '0;
            idx_in   = '0;
            state_in = T_RG_FIRST;
         end
         T_RG_FIRST: begin
            cur_in   = rd_ff;
            state_in = T_RG_A;
         end
         T_RG_A: begin
            rd_addr  = idx_p1;
            state_in = T_RG_B;
         end
         T_RG_B: begin
            nxt_in   = rd_ff;
            rd_addr  = idx_pm;
            state_in = T_RG_C;
         end
         T_RG_C: begin
            wr_en   = 1'b1;
            wr_data = v;
            cur_in  = nxt_ff;
            if (idx_ff == TW_LAST) begin
               pos_in   = '0;
               state_in = T_DR_A;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = T_RG_A;
            end
         end
         // Draw: read one word and temper it.
         T_DR_A: begin
            rd_addr  = pos_ff;
            state_in = T_DR_B;
         end
         T_DR_B: begin
            word_in       = icr_temper(rd_ff);
            word_valid_in = 1'b1;
            pos_in        = pos_ff + 1'b1;
            state_in      = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         pos_ff        <= TW_COUNT;
         word_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         word_valid_ff <= word_valid_in;
      end
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      prod_ff <= prod_in;
      cur_ff  <= cur_in;
      nxt_ff  <= nxt_in;
      word_ff <= word_in;
   end

   // State word memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tw_mem[wr_addr] <= wr_data;
      end
      rd_ff <= tw_mem[rd_addr];
   end

   assign tw_rsp.busy       = (state_ff != T_IDLE);
   assign tw_rsp.word_valid = word_valid_ff;
   assign tw_rsp.word       = word_ff;

endmodule

`default_nettype wire

// File: hdl/independent_cascade_run_unit.sv
// Independent cascade run unit: add edge, clear graph, reseed (twister seeding, a multiply
// and an add-and-write per word) and run. Run clears the active marks and queues the seed,
// then reads each reached node and each of its arcs, draws for each arc to an inactive node,
// regenerates the 624 twister words when they are used up, and finishes; one item at a time,
// taken only in the idle state.
// Reset is synchronous; after it the unit sweeps the node lists and seeds the twister
// before it takes the first item (configuration writes are taken anyway).
`default_nettype none

module independent_cascade_run_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire [icr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [icr_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   icr_req_if.sink                            req_chan,
   icr_rsp_if.source                          rsp_chan
);
   import icr_pkg::*;

   typedef enum logic [4:0] {
      S_BOOT, S_SWEEP, S_SETTLE, S_IDLE, S_RESEED,
      S_ADD_RD_A, S_ADD_WR_A, S_ADD_RD_B, S_ADD_WR_B,
      S_RUN_CLR, S_RUN_SEED, S_POP, S_POP_RD, S_NODE,
      S_ARC, S_ARC_RD, S_CHECK, S_DRAW, S_DONE
   } state_type;

   localparam logic [NODE_W-1:0]  NODE_LAST = NODE_W'(MAX_NODES - 1);
   localparam logic [COUNT_W-1:0] NODE_MAX  = COUNT_W'(MAX_NODES);
   localparam logic [ARCS_W-1:0]  ARCS_LIM  = ARCS_W'(MAX_ARCS - 2);

   state_type             state_ff, state_in;
   logic                  boot_ff, boot_in;
   logic [NODE_W-1:0]     sweep_ff, sweep_in;
   logic [NODE_W-1:0]     na_ff, na_in;
   logic [NODE_W-1:0]     nb_ff, nb_in;
   logic [ARCS_W-1:0]     arcs_ff, arcs_in;
   logic [COUNT_W-1:0]    head_ff, head_in;
   logic [COUNT_W-1:0]    tail_ff, tail_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ARC_W-1:0]      arc_ff, arc_in;
   logic [ARC_W-1:0]      last_ff, last_in;
   logic [ARC_W-1:0]      link_ff, link_in;
   logic [NODE_W-1:0]     nbr_ff, nbr_in;
   logic [COUNT_W-1:0]    res_count_ff, res_count_in;
   icr_status_type        res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   icr_status_type        rsp_status_ff, rsp_status_in;
   logic [THRESH_W-1:0]   thr_ff, thr_in;
   logic [SEED_W-1:0]     seed_ff, seed_in;
   logic [COUNT_W-1:0]    ncount_ff, ncount_in;

   // Graph, activity and frontier memories.
   icr_node_type          node_mem [MAX_NODES];
   logic [NODE_W-1:0]     arc_nb_mem [MAX_ARCS];
   logic [ARC_W-1:0]      arc_link_mem [MAX_ARCS];
   logic                  active_mem [MAX_NODES];
   logic [NODE_W-1:0]     fifo_mem [MAX_NODES];

   icr_node_type          node_rd_ff, node_wr_data;
   logic [NODE_W-1:0]     node_rd_addr, node_wr_addr;
   logic                  node_wr_en;
   logic [NODE_W-1:0]     arc_nb_rd_ff, arc_nb_wr_data;
   logic [ARC_W-1:0]      arc_link_rd_ff, arc_link_wr_data;
   logic [ARC_W-1:0]      arc_rd_addr, arc_nb_wr_addr, arc_link_wr_addr;
   logic                  arc_nb_wr_en, arc_link_wr_en;
   logic                  act_rd_ff, act_wr_data, act_wr_en;
   logic [NODE_W-1:0]     act_rd_addr, act_wr_addr;
   logic [NODE_W-1:0]     fifo_rd_ff, fifo_wr_data, fifo_rd_addr, fifo_wr_addr;
   logic                  fifo_wr_en;

   icr_tw_req_type        tw_req;
   icr_tw_rsp_type        tw_rsp;

   logic [COUNT_W-1:0]    node_lim;
   logic                  req_xfer;

   icr_twister u_twister (
      .clock  (clock),
      .reset  (reset),
      .tw_req (tw_req),
      .tw_rsp (tw_rsp)
   );

   assign node_lim = (ncount_ff > NODE_MAX) ? NODE_MAX : ncount_ff;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.active_total = rsp_count_ff;
   assign rsp_chan.status       = rsp_status_ff;

   // Sequencer: next state, memory control and result handling.
   always_comb begin
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
      logic [ARC_W-1:0]  new_arc;
      logic              arc_done;

      state_in      = state_ff;
      boot_in       = boot_ff;
      sweep_in      = sweep_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      arcs_in       = arcs_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      arc_in        = arc_ff;
      last_in       = last_ff;
      link_in       = link_ff;
      nbr_in        = nbr_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      node_wr_en       = 1'b0;
      node_wr_addr     = sweep_ff;
      node_wr_data     = '0;
      node_rd_addr     = na_ff;
      arc_nb_wr_en     = 1'b0;
      arc_nb_wr_addr   = arcs_ff[ARC_W-1:0];
      arc_nb_wr_data   = nb_ff;
      arc_link_wr_en   = 1'b0;
      arc_link_wr_addr = node_rd_ff.last;
      arc_link_wr_data = arcs_ff[ARC_W-1:0];
      arc_rd_addr      = arc_ff;
      act_wr_en        = 1'b0;
      act_wr_addr      = sweep_ff;
      act_wr_data      = 1'b0;
      act_rd_addr      = arc_nb_rd_ff;
      fifo_wr_en       = 1'b0;
      fifo_wr_addr     = tail_ff[NODE_W-1:0];
      fifo_wr_data     = nbr_ff;
      fifo_rd_addr     = head_ff[NODE_W-1:0];

      tw_req.seed       = 1'b0;
      tw_req.draw       = 1'b0;
      tw_req.seed_value = seed_ff;

      from_node = na_ff;
      to_node   = nb_ff;
      new_arc   = arcs_ff[ARC_W-1:0];
      arc_done  = (arc_ff == last_ff);

      unique case (state_ff)
         S_BOOT: begin
            tw_req.seed = 1'b1;
            sweep_in    = '0;
            state_in    = S_SWEEP;
         end
         // Empty every node list, one entry per cycle.
         S_SWEEP: begin
            node_wr_en = 1'b1;
            sweep_in   = sweep_ff + 1'b1;
            if (sweep_ff == NODE_LAST) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            if (!tw_rsp.busy) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               na_in         = req_chan.node_a;
               nb_in         = req_chan.node_b;
               res_count_in  = '0;
               res_status_in = STATUS_OK;
               unique case (icr_action_type'(req_chan.action))
                  ACT_ADD_EDGE: begin
                     if ({1'b0, req_chan.node_a} >= node_lim ||
                         {1'b0, req_chan.node_b} >= node_lim) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = S_DONE;
                     end else if (arcs_ff > ARCS_LIM) begin
                        res_status_in = STATUS_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_ADD_RD_A;
                     end
                  end
                  ACT_RUN: begin
                     if ({1'b0, req_chan.node_a} >= node_lim) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        sweep_in = '0;
                        state_in = S_RUN_CLR;
                     end
                  end
                  ACT_CLEAR: begin
                     arcs_in  = '0;
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  ACT_RESEED: begin
                     state_in = S_RESEED;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RESEED: begin
            tw_req.seed = 1'b1;
            state_in    = S_SETTLE;
         end
         // Add edge: append one arc to each endpoint's list.
         S_ADD_RD_A: begin
            node_rd_addr = na_ff;
            state_in     = S_ADD_WR_A;
         end
         S_ADD_RD_B: begin
            node_rd_addr = nb_ff;
            state_in     = S_ADD_WR_B;
         end
         S_ADD_WR_A, S_ADD_WR_B: begin
            if (state_ff == S_ADD_WR_B) begin
               from_node = nb_ff;
               to_node   = na_ff;
            end
            arc_nb_wr_en   = 1'b1;
            arc_nb_wr_data = to_node;
            arc_link_wr_en = node_rd_ff.nonempty;
            node_wr_en     = 1'b1;
            node_wr_addr   = from_node;
            node_wr_data.nonempty = 1'b1;
            node_wr_data.first    = node_rd_ff.nonempty ? node_rd_ff.first : new_arc;
            node_wr_data.last     = new_arc;
            arcs_in  = arcs_ff + 1'b1;
            state_in = (state_ff == S_ADD_WR_A) ? S_ADD_RD_B : S_DONE;
         end
         // Run: clear the active marks, then a breadth-first walk.
         S_RUN_CLR: begin
            act_wr_en = 1'b1;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == NODE_LAST) begin
               state_in = S_RUN_SEED;
            end
         end
         S_RUN_SEED: begin
            act_wr_en    = 1'b1;
            act_wr_addr  = na_ff;
            act_wr_data  = 1'b1;
            fifo_wr_en   = 1'b1;
            fifo_wr_addr = '0;
            fifo_wr_data = na_ff;
            head_in      = '0;
            tail_in      = COUNT_W'(1);
            count_in     = COUNT_W'(1);
            state_in     = S_POP;
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               res_count_in = count_ff;
               state_in     = S_DONE;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = S_POP_RD;
            end
         end
         S_POP_RD: begin
            node_rd_addr = fifo_rd_ff;
            state_in     = S_NODE;
         end
         S_NODE: begin
            if (node_rd_ff.nonempty) begin
               arc_in   = node_rd_ff.first;
               last_in  = node_rd_ff.last;
               state_in = S_ARC;
            end else begin
               state_in = S_POP;
            end
         end
         S_ARC: begin
            arc_rd_addr = arc_ff;
            state_in    = S_ARC_RD;
         end
         S_ARC_RD: begin
            nbr_in      = arc_nb_rd_ff;
            link_in     = arc_link_rd_ff;
            act_rd_addr = arc_nb_rd_ff;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (!act_rd_ff) begin
               tw_req.draw = 1'b1;
               state_in    = S_DRAW;
            end else begin
               arc_in   = link_ff;
               state_in = arc_done ? S_POP : S_ARC;
            end
         end
         S_DRAW: begin
            if (tw_rsp.word_valid) begin
               if ({1'b0, tw_rsp.word} < thr_ff) begin
                  act_wr_en   = 1'b1;
                  act_wr_addr = nbr_ff;
                  act_wr_data = 1'b1;
                  count_in    = count_ff + 1'b1;
                  if (!tail_ff[COUNT_W-1]) begin
                     fifo_wr_en = 1'b1;
                     tail_in    = tail_ff + 1'b1;
                  end
               end
               arc_in   = link_ff;
               state_in = arc_done ? S_POP : S_ARC;
            end
         end
         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Configuration register writes.
   always_comb begin
      thr_in    = thr_ff;
      seed_in   = seed_ff;
      ncount_in = ncount_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD:  thr_in    = csr_wr_data[THRESH_W-1:0];
            CSR_SEED:       seed_in   = csr_wr_data[SEED_W-1:0];
            CSR_NODE_COUNT: ncount_in = csr_wr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_BOOT;
         boot_ff       <= 1'b1;
         arcs_ff       <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= THRESH_RESET;
         seed_ff       <= SEED_RESET;
         ncount_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         boot_ff       <= boot_in;
         arcs_ff       <= arcs_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         thr_ff        <= thr_in;
         seed_ff       <= seed_in;
         ncount_ff     <= ncount_in;
      end
      sweep_ff      <= sweep_in;
      na_ff         <= na_in;
      nb_ff         <= nb_in;
      arc_ff        <= arc_in;
      last_ff       <= last_in;
      link_ff       <= link_in;
      nbr_ff        <= nbr_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Node list descriptors.
   always_ff @(posedge clock) begin
      if (node_wr_en) begin
         node_mem[node_wr_addr] <= node_wr_data;
      end
      node_rd_ff <= node_mem[node_rd_addr];
   end

   // Arc neighbour store.
   always_ff @(posedge clock) begin
      if (arc_nb_wr_en) begin
         arc_nb_mem[arc_nb_wr_addr] <= arc_nb_wr_data;
      end
      arc_nb_rd_ff <= arc_nb_mem[arc_rd_addr];
   end

   // Arc link store.
   always_ff @(posedge clock) begin
      if (arc_link_wr_en) begin
         arc_link_mem[arc_link_wr_addr] <= arc_link_wr_data;
      end
      arc_link_rd_ff <= arc_link_mem[arc_rd_addr];
   end

   // Active marks.
   always_ff @(posedge clock) begin
      if (act_wr_en) begin
         active_mem[act_wr_addr] <= act_wr_data;
      end
      act_rd_ff <= active_mem[act_rd_addr];
   end

   // Frontier queue.
   always_ff @(posedge clock) begin
      if (fifo_wr_en) begin
         fifo_mem[fifo_wr_addr] <= fifo_wr_data;
      end
      fifo_rd_ff <= fifo_mem[fifo_rd_addr];
   end

`ifndef NO_ASSERTIONS
   // A twister word only arrives while the walk waits for it.
   assert property (@(posedge clock) disable iff (reset)
      tw_rsp.word_valid |-> state_ff == S_DRAW)
      else $error("twister word outside a draw");

   // The frontier read pointer never passes the write pointer.
   assert property (@(posedge clock) disable iff (reset) head_ff <= tail_ff)
      else $error("frontier head past tail");

   // Every queued node was counted as active.
   assert property (@(posedge clock) disable iff (reset) tail_ff <= count_ff)
      else $error("frontier holds more nodes than were activated");

   // Arcs are added in pairs; the count is odd only between the two appends.
   assert property (@(posedge clock) disable iff (reset)
      !arcs_ff[0] || state_ff == S_ADD_RD_B || state_ff == S_ADD_WR_B)
      else $error("odd arc count");
`endif

endmodule

`default_nettype wire
